// ===== rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the NTC averager RTL.
// Assertions are dropped when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
`define NTC_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("assertion failed");
`define NTC_NEVER(lbl, clk, rst, cond) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) \
      else $error("forbidden condition seen");
`else
`define NTC_ASSERT(lbl, clk, rst, prop)
`define NTC_NEVER(lbl, clk, rst, cond)
`endif

`endif

// ===== rtl/ntc_pkg.sv =====
// ----------------------------------------------------------------------------
// ntc_pkg
// Widths, constants, codes and shared types of the NTC averager.
// ----------------------------------------------------------------------------
`default_nettype none
package ntc_pkg;

   localparam int ADC_BITS     = 10;
   localparam int LN_FRAC_BITS = 16;

   localparam int TIME_W     = 32;
   localparam int INTERVAL_W = 16;
   localparam int COUNT_W    = 8;
   localparam int FS_W       = 11;
   localparam int BAL_W      = 20;
   localparam int CORR_W     = 15;
   localparam int TEMP_W     = 17;
   localparam int SUM_W      = 18;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 20;

   localparam int NUM_W  = 31;   // log operand
   localparam int LN_W   = 21;   // ln result, Q5.16
   localparam int MAG_W  = 21;
   localparam int L2_W   = 25;
   localparam int L3_W   = 30;
   localparam int TB_W   = 38;
   localparam int TC_W   = 34;
   localparam int D_W    = 40;   // signed denominator
   localparam int DIVN_W = 50;
   localparam int DIVD_W = 38;
   localparam int T_W    = 52;

   localparam logic [9:0]         MS_PER_S     = 10'd1000;
   localparam logic [ADC_BITS-1:0] MAX_AVG     = {ADC_BITS{1'b1}};
   localparam logic [33:0]        SH_A         = 34'd11291480000;
   localparam logic [31:0]        SH_B         = 32'd2341250000;
   localparam logic [19:0]        SH_C         = 20'd876741;
   localparam logic [DIVN_W-1:0]  CENTI_SCALE  = 50'd1000000000000000;
   localparam logic [31:0]        LN2_Q32      = 32'hB17217F8;
   localparam logic [T_W-1:0]     KELVIN_CENTI = 52'd27315;
   localparam logic signed [TEMP_W-1:0] TEMP_HI = 17'sd40000;
   localparam logic signed [TEMP_W-1:0] TEMP_LO = -17'sd40000;

   localparam logic [CSR_IDX_W-1:0] REG_ENABLED    = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_INTERVAL   = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_COUNT      = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_FULL_SCALE = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_BALANCE    = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_CORRECTION = 3'd5;

   typedef enum logic [4:0] {
      OP_NONE, OP_LATCH, OP_POLL, OP_AVG_START, OP_AVG_TAKE,
      OP_LNA_START, OP_LNA_TAKE, OP_LNB_TAKE, OP_MUL1, OP_MUL2, OP_MUL3,
      OP_FORM_D, OP_TDIV_START, OP_TDIV_TAKE, OP_OUT_LO, OP_OUT_HI, OP_OUT_TEMP
   } dp_op_type;

   typedef struct packed {
      dp_op_type op;
   } dp_cmd_type;

   typedef struct packed {
      logic finish;
      logic avg_zero;
      logic rail_hi;
      logic d_nonpos;
      logic ln_done;
      logic div_done;
      logic rsp_free;
   } dp_status_type;

   typedef enum logic [3:0] {
      ST_IDLE, ST_EVAL, ST_AVG_GO, ST_AVG_DIV, ST_CLASSIFY, ST_LN_NUM, ST_LN_AVG,
      ST_MUL1, ST_MUL2, ST_MUL3, ST_FORM_D, ST_CHECK_D, ST_T_DIV,
      ST_OUT_LO, ST_OUT_HI, ST_OUT_TEMP
   } ctrl_state_type;

   typedef enum logic [1:0] {
      LN_IDLE, LN_NORM, LN_SQUARE, LN_SCALE
   } ln_state_type;

endpackage
`default_nettype wire

// ===== rtl/ntc_chan_if.sv =====
// ----------------------------------------------------------------------------
// NTC channel interfaces
// Poll channel and result channel, valid/ready with payload.
// ----------------------------------------------------------------------------
`default_nettype none
interface ntc_req_if;
   logic                        valid;
   logic                        ready;
   logic [ntc_pkg::TIME_W-1:0]  time_ms;
   logic [ntc_pkg::ADC_BITS-1:0] adc_sample;
   modport source (output valid, time_ms, adc_sample, input ready);
   modport sink   (input valid, time_ms, adc_sample, output ready);
endinterface

interface ntc_rsp_if;
   logic                               valid;
   logic                               ready;
   logic signed [ntc_pkg::TEMP_W-1:0]  temperature_centi;
   logic [ntc_pkg::ADC_BITS-1:0]       average_reading;
   logic                               range_error;
   modport source (output valid, temperature_centi, average_reading, range_error,
                   input ready);
   modport sink   (input valid, temperature_centi, average_reading, range_error,
                   output ready);
endinterface
`default_nettype wire

// ===== rtl/ntc_div.sv =====
// ----------------------------------------------------------------------------
// ntc_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none
module ntc_div (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       start,
   input  wire logic [ntc_pkg::DIVN_W-1:0] dividend,
   input  wire logic [ntc_pkg::DIVD_W-1:0] divisor,
   output logic                            done,
   output logic [ntc_pkg::DIVN_W-1:0]      quotient
);
   localparam int CNT_W = $clog2(ntc_pkg::DIVN_W + 1);

   logic                        busy_ff, busy_in;
   logic                        done_ff, done_in;
   logic [CNT_W-1:0]            cnt_ff, cnt_in;
   logic [ntc_pkg::DIVD_W-1:0]  rem_ff, rem_in;
   logic [ntc_pkg::DIVD_W-1:0]  dsor_ff, dsor_in;
   logic [ntc_pkg::DIVN_W-1:0]  quo_ff, quo_in;
   logic [ntc_pkg::DIVD_W:0]    trial;
   logic [ntc_pkg::DIVD_W:0]    diff;

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      dsor_in = dsor_ff;
      quo_in  = quo_ff;
      trial   = {rem_ff, quo_ff[ntc_pkg::DIVN_W-1]};
      diff    = trial - {1'b0, dsor_ff};
      if (busy_ff) begin
         if (trial >= {1'b0, dsor_ff}) begin
            rem_in = diff[ntc_pkg::DIVD_W-1:0];
            quo_in = {quo_ff[ntc_pkg::DIVN_W-2:0], 1'b1};
         end else begin
            rem_in = trial[ntc_pkg::DIVD_W-1:0];
            quo_in = {quo_ff[ntc_pkg::DIVN_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end else if (start) begin
         busy_in = 1'b1;
         cnt_in  = CNT_W'(ntc_pkg::DIVN_W);
         rem_in  = '0;
         dsor_in = divisor;
         quo_in  = dividend;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff  <= rem_in;
      dsor_ff <= dsor_in;
      quo_ff  <= quo_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;
endmodule
`default_nettype wire

// ===== rtl/ntc_log.sv =====
// ----------------------------------------------------------------------------
// ntc_log
// Natural log in Q5.16: normalise, square per fraction bit, scale by ln2.
// ----------------------------------------------------------------------------
`default_nettype none
module ntc_log (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      start,
   input  wire logic [ntc_pkg::NUM_W-1:0] operand,
   output logic                           done,
   output logic [ntc_pkg::LN_W-1:0]       result
);
   localparam int FB  = ntc_pkg::LN_FRAC_BITS;
   localparam int IT_W = $clog2(FB + 1);

   ntc_pkg::ln_state_type state_ff, state_in;
   logic [30:0]             m_ff, m_in;
   logic [4:0]              k_ff, k_in;
   logic [FB-1:0]           frac_ff, frac_in;
   logic [IT_W-1:0]         iter_ff, iter_in;
   logic                    done_ff, done_in;
   logic [ntc_pkg::LN_W-1:0] result_ff, result_in;
   logic [61:0]             sq;
   logic [31:0]             sq_hi;
   logic [52:0]             scaled;

   always_comb begin
      state_in  = state_ff;
      m_in      = m_ff;
      k_in      = k_ff;
      frac_in   = frac_ff;
      iter_in   = iter_ff;
      done_in   = 1'b0;
      result_in = result_ff;
      sq        = {31'b0, m_ff} * {31'b0, m_ff};
      sq_hi     = sq[61:30];
      scaled    = {32'b0, k_ff, frac_ff} * {21'b0, ntc_pkg::LN2_Q32} + 53'h80000000;
      case (state_ff)
         ntc_pkg::LN_IDLE: begin
            if (start) begin
               m_in = operand;
               k_in = 5'd30;
               if (operand == '0) begin
                  result_in = '0;
                  done_in   = 1'b1;
               end else begin
                  state_in = ntc_pkg::LN_NORM;
               end
            end
         end
         ntc_pkg::LN_NORM: begin
            if (m_ff[30]) begin
               iter_in  = IT_W'(FB);
               state_in = ntc_pkg::LN_SQUARE;
            end else begin
               m_in = {m_ff[29:0], 1'b0};
               k_in = k_ff - 1'b1;
            end
         end
         ntc_pkg::LN_SQUARE: begin
            if (sq_hi[31]) begin
               m_in    = sq_hi[31:1];
               frac_in = {frac_ff[FB-2:0], 1'b1};
            end else begin
               m_in    = sq_hi[30:0];
               frac_in = {frac_ff[FB-2:0], 1'b0};
            end
            iter_in = iter_ff - 1'b1;
            if (iter_ff == IT_W'(1))
               state_in = ntc_pkg::LN_SCALE;
         end
         ntc_pkg::LN_SCALE: begin
            result_in = scaled[52:32];
            done_in   = 1'b1;
            state_in  = ntc_pkg::LN_IDLE;
         end
         default: state_in = ntc_pkg::LN_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ntc_pkg::LN_IDLE;
         done_ff  <= 1'b0;
         iter_ff  <= '0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
         iter_ff  <= iter_in;
      end
      m_ff      <= m_in;
      k_ff      <= k_in;
      frac_ff   <= frac_in;
      result_ff <= result_in;
   end

   assign done   = done_ff;
   assign result = result_ff;
endmodule
`default_nettype wire

// ===== rtl/ntc_ctrl.sv =====
// ----------------------------------------------------------------------------
// ntc_ctrl
// Sequencer: poll handling, then the conversion steps of a finished round.
// ----------------------------------------------------------------------------
`default_nettype none
module ntc_ctrl (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_ready,
   input  wire ntc_pkg::dp_status_type status,
   output ntc_pkg::dp_cmd_type        cmd
);
   ntc_pkg::ctrl_state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ntc_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd.op    = ntc_pkg::OP_NONE;
      req_ready = 1'b0;
      case (state_ff)
         ntc_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.op   = ntc_pkg::OP_LATCH;
               state_in = ntc_pkg::ST_EVAL;
            end
         end
         ntc_pkg::ST_EVAL: begin
            cmd.op   = ntc_pkg::OP_POLL;
            state_in = status.finish ? ntc_pkg::ST_AVG_GO : ntc_pkg::ST_IDLE;
         end
         ntc_pkg::ST_AVG_GO: begin
            cmd.op   = ntc_pkg::OP_AVG_START;
            state_in = ntc_pkg::ST_AVG_DIV;
         end
         ntc_pkg::ST_AVG_DIV: begin
            if (status.div_done) begin
               cmd.op   = ntc_pkg::OP_AVG_TAKE;
               state_in = ntc_pkg::ST_CLASSIFY;
            end
         end
         ntc_pkg::ST_CLASSIFY: begin
            if (status.avg_zero) begin
               state_in = ntc_pkg::ST_OUT_LO;
            end else if (status.rail_hi) begin
               state_in = ntc_pkg::ST_OUT_HI;
            end else begin
               cmd.op   = ntc_pkg::OP_LNA_START;
               state_in = ntc_pkg::ST_LN_NUM;
            end
         end
         ntc_pkg::ST_LN_NUM: begin
            if (status.ln_done) begin
               cmd.op   = ntc_pkg::OP_LNA_TAKE;
               state_in = ntc_pkg::ST_LN_AVG;
            end
         end
         ntc_pkg::ST_LN_AVG: begin
            if (status.ln_done) begin
               cmd.op   = ntc_pkg::OP_LNB_TAKE;
               state_in = ntc_pkg::ST_MUL1;
            end
         end
         ntc_pkg::ST_MUL1: begin
            cmd.op   = ntc_pkg::OP_MUL1;
            state_in = ntc_pkg::ST_MUL2;
         end
         ntc_pkg::ST_MUL2: begin
            cmd.op   = ntc_pkg::OP_MUL2;
            state_in = ntc_pkg::ST_MUL3;
         end
         ntc_pkg::ST_MUL3: begin
            cmd.op   = ntc_pkg::OP_MUL3;
            state_in = ntc_pkg::ST_FORM_D;
         end
         ntc_pkg::ST_FORM_D: begin
            cmd.op   = ntc_pkg::OP_FORM_D;
            state_in = ntc_pkg::ST_CHECK_D;
         end
         ntc_pkg::ST_CHECK_D: begin
            if (status.d_nonpos) begin
               state_in = ntc_pkg::ST_OUT_HI;
            end else begin
               cmd.op   = ntc_pkg::OP_TDIV_START;
               state_in = ntc_pkg::ST_T_DIV;
            end
         end
         ntc_pkg::ST_T_DIV: begin
            if (status.div_done) begin
               cmd.op   = ntc_pkg::OP_TDIV_TAKE;
               state_in = ntc_pkg::ST_OUT_TEMP;
            end
         end
         ntc_pkg::ST_OUT_LO: begin
            if (status.rsp_free) begin
               cmd.op   = ntc_pkg::OP_OUT_LO;
               state_in = ntc_pkg::ST_IDLE;
            end
         end
         ntc_pkg::ST_OUT_HI: begin
            if (status.rsp_free) begin
               cmd.op   = ntc_pkg::OP_OUT_HI;
               state_in = ntc_pkg::ST_IDLE;
            end
         end
         ntc_pkg::ST_OUT_TEMP: begin
            if (status.rsp_free) begin
               cmd.op   = ntc_pkg::OP_OUT_TEMP;
               state_in = ntc_pkg::ST_IDLE;
            end
         end
         default: state_in = ntc_pkg::ST_IDLE;
      endcase
   end
endmodule
`default_nettype wire

// ===== rtl/ntc_dp.sv =====
// ----------------------------------------------------------------------------
// ntc_dp
// Datapath: configuration, round state, divider, log unit, result register.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"
module ntc_dp (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            csr_write_enable,
   input  wire logic [ntc_pkg::CSR_IDX_W-1:0]   csr_index,
   input  wire logic [ntc_pkg::CSR_DATA_W-1:0]  csr_write_data,
   input  wire logic [ntc_pkg::TIME_W-1:0]      poll_time,
   input  wire logic [ntc_pkg::ADC_BITS-1:0]    poll_sample,
   input  wire ntc_pkg::dp_cmd_type             cmd,
   output ntc_pkg::dp_status_type               status,
   output logic                                 rsp_valid,
   input  wire logic                            rsp_ready,
   output logic signed [ntc_pkg::TEMP_W-1:0]    rsp_temp,
   output logic [ntc_pkg::ADC_BITS-1:0]         rsp_avg,
   output logic                                 rsp_err
);
   localparam int FB = ntc_pkg::LN_FRAC_BITS;

   // configuration
   logic                              en_ff;
   logic [ntc_pkg::INTERVAL_W-1:0]    interval_ff;
   logic [ntc_pkg::COUNT_W-1:0]       count_ff;
   logic [ntc_pkg::FS_W-1:0]          fs_ff;
   logic [ntc_pkg::BAL_W-1:0]         bal_ff;
   logic signed [ntc_pkg::CORR_W-1:0] corr_ff;

   // poll and round
   logic [ntc_pkg::TIME_W-1:0]   ptime_ff;
   logic [ntc_pkg::ADC_BITS-1:0] psample_ff;
   logic [ntc_pkg::TIME_W-1:0]   start_ff;
   logic [ntc_pkg::COUNT_W-1:0]  taken_ff;
   logic [ntc_pkg::SUM_W-1:0]    sum_ff;

   // conversion
   logic [ntc_pkg::ADC_BITS-1:0] avg_ff;
   logic [ntc_pkg::LN_W-1:0]     lna_ff;
   logic [ntc_pkg::MAG_W-1:0]    mag_ff;
   logic                         neg_ff;
   logic [ntc_pkg::L2_W-1:0]     l2_ff;
   logic [ntc_pkg::L3_W-1:0]     l3_ff;
   logic [ntc_pkg::TB_W-1:0]     tb_ff;
   logic [ntc_pkg::TC_W-1:0]     tc_ff;
   logic signed [ntc_pkg::D_W-1:0] d_ff;
   logic signed [ntc_pkg::TEMP_W-1:0] temp_ff;
   logic                         err_ff;

   // result register
   logic                              rsp_valid_ff;
   logic signed [ntc_pkg::TEMP_W-1:0] rsp_temp_ff;
   logic [ntc_pkg::ADC_BITS-1:0]      rsp_avg_ff;
   logic                              rsp_err_ff;

   logic [ntc_pkg::TIME_W-1:0] start_eff;
   logic [ntc_pkg::TIME_W-1:0] elapsed;
   logic [25:0]                limit;
   logic                       poll_wait;
   logic                       poll_add;
   logic [ntc_pkg::FS_W-1:0]   fs_minus;
   logic [ntc_pkg::NUM_W-1:0]  num;

   logic                       div_start, div_done;
   logic [ntc_pkg::DIVN_W-1:0] div_n, div_q;
   logic [ntc_pkg::DIVD_W-1:0] div_d;
   logic                       ln_start, ln_done;
   logic [ntc_pkg::NUM_W-1:0]  ln_opnd;
   logic [ntc_pkg::LN_W-1:0]   ln_res;

   logic [ntc_pkg::LN_W:0]     ldiff;
   logic [ntc_pkg::LN_W:0]     lneg;
   logic [42:0]                sq_r;
   logic [53:0]                tb_r;
   logic [46:0]                l3_r;
   logic [50:0]                tc_r;
   logic [ntc_pkg::D_W-1:0]    bc_sum;
   logic signed [ntc_pkg::T_W-1:0] t_val;

   always_comb begin
      start_eff = (start_ff == '0) ? ptime_ff : start_ff;
      elapsed   = ptime_ff - start_eff;
      limit     = {10'b0, interval_ff} * {16'b0, ntc_pkg::MS_PER_S};
      poll_wait = elapsed < {6'b0, limit};
      poll_add  = taken_ff < count_ff;
      fs_minus  = fs_ff - {1'b0, avg_ff};
      num       = {11'b0, bal_ff} * {20'b0, fs_minus};

      status.finish   = en_ff && !poll_wait && !poll_add;
      status.avg_zero = (avg_ff == '0);
      status.rail_hi  = ({1'b0, avg_ff} >= fs_ff) || (bal_ff == '0);
      status.d_nonpos = d_ff[ntc_pkg::D_W-1] || (d_ff == '0);
      status.ln_done  = ln_done;
      status.div_done = div_done;
      status.rsp_free = !rsp_valid_ff || rsp_ready;

      div_start = (cmd.op == ntc_pkg::OP_AVG_START) || (cmd.op == ntc_pkg::OP_TDIV_START);
      if (cmd.op == ntc_pkg::OP_AVG_START) begin
         div_n = {{(ntc_pkg::DIVN_W-ntc_pkg::SUM_W){1'b0}}, sum_ff};
         div_d = {{(ntc_pkg::DIVD_W-ntc_pkg::COUNT_W){1'b0}}, count_ff};
      end else begin
         // 1e15 + d/2, d known positive and below 2^38
         div_n = ntc_pkg::CENTI_SCALE + {12'b0, 1'b0, d_ff[37:1]};
         div_d = d_ff[ntc_pkg::DIVD_W-1:0];
      end

      ln_start = (cmd.op == ntc_pkg::OP_LNA_START) || (cmd.op == ntc_pkg::OP_LNA_TAKE);
      ln_opnd  = (cmd.op == ntc_pkg::OP_LNA_START) ? num
                 : {{(ntc_pkg::NUM_W-ntc_pkg::ADC_BITS){1'b0}}, avg_ff};

      ldiff  = {1'b0, lna_ff} - {1'b0, ln_res};
      lneg   = -ldiff;
      sq_r   = {22'b0, mag_ff} * {22'b0, mag_ff} + 43'(1 << (FB - 1));
      tb_r   = {22'b0, ntc_pkg::SH_B} * {33'b0, mag_ff} + 54'(1 << (FB - 1));
      l3_r   = {22'b0, l2_ff} * {26'b0, mag_ff} + 47'(1 << (FB - 1));
      tc_r   = {31'b0, ntc_pkg::SH_C} * {21'b0, l3_ff} + 51'(1 << (FB - 1));
      bc_sum = {2'b0, tb_ff} + {6'b0, tc_ff};
      t_val  = $signed({2'b0, div_q}) - $signed(ntc_pkg::KELVIN_CENTI)
               + $signed({{(ntc_pkg::T_W-ntc_pkg::CORR_W){corr_ff[ntc_pkg::CORR_W-1]}},
                          corr_ff});
   end

   ntc_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_n),
      .divisor  (div_d),
      .done     (div_done),
      .quotient (div_q)
   );

   ntc_log u_log (
      .clock   (clock),
      .reset   (reset),
      .start   (ln_start),
      .operand (ln_opnd),
      .done    (ln_done),
      .result  (ln_res)
   );

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         en_ff       <= 1'b0;
         interval_ff <= 16'd60;
         count_ff    <= 8'd10;
         fs_ff       <= 11'd1024;
         bal_ff      <= 20'd10000;
         corr_ff     <= '0;
      end else if (csr_write_enable) begin
         case (csr_index)
            ntc_pkg::REG_ENABLED:    en_ff       <= csr_write_data[0];
            ntc_pkg::REG_INTERVAL:   interval_ff <= csr_write_data[ntc_pkg::INTERVAL_W-1:0];
            ntc_pkg::REG_COUNT:      count_ff    <= csr_write_data[ntc_pkg::COUNT_W-1:0];
            ntc_pkg::REG_FULL_SCALE: fs_ff       <= csr_write_data[ntc_pkg::FS_W-1:0];
            ntc_pkg::REG_BALANCE:    bal_ff      <= csr_write_data[ntc_pkg::BAL_W-1:0];
            ntc_pkg::REG_CORRECTION: corr_ff     <= $signed(csr_write_data[ntc_pkg::CORR_W-1:0]);
            default: ;
         endcase
      end
   end

   // round state and result register
   always_ff @(posedge clock) begin
      if (reset) begin
         start_ff     <= '0;
         taken_ff     <= '0;
         sum_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd.op == ntc_pkg::OP_POLL && en_ff) begin
            start_ff <= start_eff;
            if (!poll_wait && poll_add) begin
               sum_ff   <= sum_ff + {{(ntc_pkg::SUM_W-ntc_pkg::ADC_BITS){1'b0}}, psample_ff};
               taken_ff <= taken_ff + 1'b1;
            end
         end
         if (cmd.op == ntc_pkg::OP_OUT_LO || cmd.op == ntc_pkg::OP_OUT_HI ||
             cmd.op == ntc_pkg::OP_OUT_TEMP) begin
            start_ff     <= '0;
            taken_ff     <= '0;
            sum_ff       <= '0;
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // payload
   always_ff @(posedge clock) begin
      case (cmd.op)
         ntc_pkg::OP_LATCH: begin
            ptime_ff   <= poll_time;
            psample_ff <= poll_sample;
         end
         ntc_pkg::OP_AVG_TAKE: begin
            if (count_ff == '0)
               avg_ff <= '0;
            else if (div_q > {{(ntc_pkg::DIVN_W-ntc_pkg::ADC_BITS){1'b0}}, ntc_pkg::MAX_AVG})
               avg_ff <= ntc_pkg::MAX_AVG;
            else
               avg_ff <= div_q[ntc_pkg::ADC_BITS-1:0];
         end
         ntc_pkg::OP_LNA_TAKE: lna_ff <= ln_res;
         ntc_pkg::OP_LNB_TAKE: begin
            neg_ff <= ldiff[ntc_pkg::LN_W];
            mag_ff <= ldiff[ntc_pkg::LN_W] ? lneg[ntc_pkg::MAG_W-1:0]
                                           : ldiff[ntc_pkg::MAG_W-1:0];
         end
         ntc_pkg::OP_MUL1: begin
            l2_ff <= sq_r[FB +: ntc_pkg::L2_W];
            tb_ff <= tb_r[FB +: ntc_pkg::TB_W];
         end
         ntc_pkg::OP_MUL2: l3_ff <= l3_r[FB +: ntc_pkg::L3_W];
         ntc_pkg::OP_MUL3: tc_ff <= tc_r[FB +: ntc_pkg::TC_W];
         ntc_pkg::OP_FORM_D: begin
            d_ff <= neg_ff ? $signed({6'b0, ntc_pkg::SH_A}) - $signed(bc_sum)
                           : $signed({6'b0, ntc_pkg::SH_A}) + $signed(bc_sum);
         end
         ntc_pkg::OP_TDIV_TAKE: begin
            if (t_val > $signed(ntc_pkg::T_W'(ntc_pkg::TEMP_HI))) begin
               temp_ff <= ntc_pkg::TEMP_HI;
               err_ff  <= 1'b1;
            end else if (t_val < -$signed(ntc_pkg::T_W'(ntc_pkg::TEMP_HI))) begin
               temp_ff <= ntc_pkg::TEMP_LO;
               err_ff  <= 1'b1;
            end else begin
               temp_ff <= t_val[ntc_pkg::TEMP_W-1:0];
               err_ff  <= 1'b0;
            end
         end
         ntc_pkg::OP_OUT_LO: begin
            rsp_temp_ff <= ntc_pkg::TEMP_LO;
            rsp_avg_ff  <= avg_ff;
            rsp_err_ff  <= 1'b1;
         end
         ntc_pkg::OP_OUT_HI: begin
            rsp_temp_ff <= ntc_pkg::TEMP_HI;
            rsp_avg_ff  <= avg_ff;
            rsp_err_ff  <= 1'b1;
         end
         ntc_pkg::OP_OUT_TEMP: begin
            rsp_temp_ff <= temp_ff;
            rsp_avg_ff  <= avg_ff;
            rsp_err_ff  <= err_ff;
         end
         default: ;
      endcase
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_temp  = rsp_temp_ff;
   assign rsp_avg   = rsp_avg_ff;
   assign rsp_err   = rsp_err_ff;

   // divider and log unit are never finishing together
   `NTC_NEVER(a_units_excl, clock, reset, div_done && ln_done)
   // a temperature result loaded for delivery always leaves an empty round behind
   `NTC_ASSERT(a_round_clear, clock, reset, (cmd.op == ntc_pkg::OP_OUT_TEMP) |=> (start_ff == '0 && taken_ff == '0 && sum_ff == '0 && rsp_valid_ff))
   // an accepted sample bumps the count by exactly one
   `NTC_ASSERT(a_sample_cnt, clock, reset, (cmd.op == ntc_pkg::OP_POLL && en_ff && !poll_wait && poll_add) |=> (taken_ff == $past(taken_ff) + 1'b1))
endmodule
`default_nettype wire

// ===== rtl/ntc_thermistor_averager_core.sv =====
// ----------------------------------------------------------------------------
// ntc_thermistor_averager_core
// NTC thermistor sampler: averages ADC polls, converts to 0.01 degC.
// ----------------------------------------------------------------------------
// Usage:
//  - req_chan carries one poll per transfer (time_ms, adc_sample), taken when
//    the sequencer is idle. An ordinary poll holds the block through capture,
//    then round update, so the next poll is taken only once that update is done.
//  - The poll that closes a round starts the conversion: an average divide,
//    two natural logs (each a normalise shift and 16 squaring steps), three
//    multiply steps, forming D and a divide for 1/D. No poll is taken
//    meanwhile. The result goes to rsp_chan before the logs when the average
//    alone sets it (zero average, high rail), after forming D when D is not
//    positive, and after the 1/D divide for a full conversion; a receiver
//    stall can delay that transfer.
//  - rsp_chan has an output register, so polls continue while a result waits;
//    a newer result waits for that transfer before it is loaded.
//  - csr_* writes a register at any edge with the write enable high; software
//    writes only while the block is idle.
//  - Reset (synchronous, active high) loads register defaults (disabled,
//    60 s, 10 samples, full scale 1024, 10 kohm, no offset) and empties the
//    round and the result register.
// ----------------------------------------------------------------------------
`default_nettype none
module ntc_thermistor_averager_core (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           csr_write_enable,
   input  wire logic [ntc_pkg::CSR_IDX_W-1:0]  csr_index,
   input  wire logic [ntc_pkg::CSR_DATA_W-1:0] csr_write_data,
   ntc_req_if.sink                             req_chan,
   ntc_rsp_if.source                           rsp_chan
);
   ntc_pkg::dp_cmd_type    cmd;
   ntc_pkg::dp_status_type status;
   logic                   ready;

   // sequencer
   ntc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (ready),
      .status    (status),
      .cmd       (cmd)
   );

   assign req_chan.ready = ready;

   // datapath with divider, log unit and result register
   ntc_dp u_dp (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .poll_time        (req_chan.time_ms),
      .poll_sample      (req_chan.adc_sample),
      .cmd              (cmd),
      .status           (status),
      .rsp_valid        (rsp_chan.valid),
      .rsp_ready        (rsp_chan.ready),
      .rsp_temp         (rsp_chan.temperature_centi),
      .rsp_avg          (rsp_chan.average_reading),
      .rsp_err          (rsp_chan.range_error)
   );
endmodule
`default_nettype wire
